@@ rtl/core/tcc_pkg.sv @@
// Shared types and constants of the text console cursor control block.
package tcc_pkg;

  localparam int unsigned TextCols = 80;
  localparam int unsigned TextRows = 37;
  localparam int unsigned TabStop  = 8;

  localparam int unsigned ColW  = 7;
  localparam int unsigned RowW  = 6;
  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] CH_TAB    = 8'h09;
  localparam logic [CharW-1:0] CH_LF     = 8'h0A;
  localparam logic [CharW-1:0] CH_FF     = 8'h0C;
  localparam logic [CharW-1:0] CH_CR     = 8'h0D;
  localparam logic [CharW-1:0] CH_ESC    = 8'h1B;
  localparam logic [CharW-1:0] CH_RUBOUT = 8'h7F;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SCROLL = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [CharW-1:0] glyph;
    logic [ColW-1:0]  cell_col;
    logic [RowW-1:0]  cell_row;
    logic [CharW-1:0] echo_byte;
    logic             echo_valid;
    logic             last;
  } result_t;

  // Results caused by one input byte: one always, a second on a wrap scroll.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } step_t;

endpackage

@@ rtl/core/tcc_stream_if.sv @@
// Stream interfaces for the character input and the renderer command output.
interface tcc_char_if;
  logic                     valid;
  logic                     ready;
  logic [tcc_pkg::CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface tcc_cmd_if;
  logic                      valid;
  logic                      ready;
  tcc_pkg::cmd_e             command;
  logic [tcc_pkg::CharW-1:0] glyph;
  logic [tcc_pkg::ColW-1:0]  cell_col;
  logic [tcc_pkg::RowW-1:0]  cell_row;
  logic [tcc_pkg::CharW-1:0] echo_byte;
  logic                      echo_valid;
  logic                      last;

  modport source (output valid, output command, output glyph, output cell_col,
                  output cell_row, output echo_byte, output echo_valid,
                  output last, input ready);
  modport sink (input valid, input command, input glyph, input cell_col,
                input cell_row, input echo_byte, input echo_valid,
                input last, output ready);
endinterface

@@ rtl/core/tcc_cursor.sv @@
// Cursor registers and the decode of one byte into renderer results.
module tcc_cursor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [tcc_pkg::CharW-1:0] char_i,
  output tcc_pkg::step_t            step_o
);
  import tcc_pkg::*;

  localparam int unsigned ColX = ColW + 1;
  localparam int unsigned RowX = RowW + 1;
  localparam logic [ColW-1:0] LastCol = ColW'(TextCols - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(TextRows - 1);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowX-1:0] row_inc;
  logic            wrap;
  logic [RowW-1:0] nl_row;
  logic [ColX-1:0] tab_col;

  always_comb begin
    row_inc = {1'b0, row_q} + RowX'(1);
    wrap    = (row_inc >= RowX'(TextRows));
    nl_row  = wrap ? LastRow : row_inc[RowW-1:0];
    tab_col = {1'b0, col_q} + ColX'(TabStop) - ColX'(col_q % TabStop);

    col_d = col_q;
    row_d = row_q;
    step_o.first  = '{command: CMD_NONE, glyph: '0, cell_col: '0, cell_row: '0,
                      echo_byte: char_i, echo_valid: 1'b1, last: 1'b1};
    step_o.second = '{command: CMD_SCROLL, glyph: '0, cell_col: '0, cell_row: '0,
                      echo_byte: '0, echo_valid: 1'b0, last: 1'b1};
    step_o.two    = 1'b0;

    case (char_i)
      CH_RUBOUT: begin
        if (col_q == '0) begin
          if (row_q != '0) begin
            row_d = row_q - RowW'(1);
            col_d = LastCol;
          end
        end else begin
          col_d = col_q - ColW'(1);
        end
        step_o.first.command  = CMD_DRAW;
        step_o.first.glyph    = CH_SPACE;
        step_o.first.cell_col = col_d;
        step_o.first.cell_row = row_d;
      end
      CH_TAB: begin
        if (tab_col > ColX'(TextCols - 1)) begin
          col_d = '0;
          row_d = nl_row;
          step_o.first.command = wrap ? CMD_SCROLL : CMD_NONE;
        end else begin
          col_d = tab_col[ColW-1:0];
        end
      end
      CH_FF: begin
        col_d = '0;
        row_d = '0;
        step_o.first.command = CMD_CLEAR;
      end
      CH_CR: begin
        col_d = '0;
      end
      CH_LF: begin
        col_d = '0;
        row_d = nl_row;
        step_o.first.command = wrap ? CMD_SCROLL : CMD_NONE;
      end
      CH_ESC: begin
        col_d = col_q;
      end
      default: begin
        step_o.first.command  = CMD_DRAW;
        step_o.first.glyph    = char_i;
        step_o.first.cell_col = col_q;
        step_o.first.cell_row = row_q;
        if (col_q == LastCol) begin
          col_d = '0;
          row_d = nl_row;
          if (wrap) begin
            step_o.two        = 1'b1;
            step_o.first.last = 1'b0;
          end
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LastCol) else $error("cursor column off screen");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= LastRow) else $error("cursor row off screen");
  a_two_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_o.two |-> (step_o.first.command == CMD_DRAW && !step_o.first.last &&
                    row_q == LastRow && col_q == LastCol))
    else $error("second result without a wrap on the last row");

endmodule

@@ rtl/core/tcc_res_fifo.sv @@
// Four-entry result queue that takes one or two results and gives one a cycle while pop_i is high.
module tcc_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcc_pkg::step_t   step_i,
  output logic             space2_o,
  output logic             valid_o,
  input  logic             pop_i,
  output tcc_pkg::result_t res_o
);
  import tcc_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_push;
  logic            do_pop;

  always_comb begin
    do_pop   = pop_i && valid_o;
    n_push   = push_i ? (step_i.two ? CntW'(2) : CntW'(1)) : '0;
    wr_ptr_d = wr_ptr_q + n_push[PtrW-1:0];
    cnt_d    = cnt_q + n_push - CntW'(do_pop);
  end

  assign space2_o = (cnt_q <= CntW'(Depth - 2));
  assign valid_o  = (cnt_q != '0);
  assign res_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= step_i.first;
      if (step_i.two) begin
        mem_q[wr_ptr_q + PtrW'(1)] <= step_i.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q <= CntW'(Depth - 2)) else $error("result queue overrun");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("result queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[PtrW-1:0] == PtrW'(wr_ptr_q - rd_ptr_q))
    else $error("result queue pointers disagree with count");

endmodule

@@ rtl/core/text_console_cursor_control.sv @@
// Top level of the text console cursor control: input register, decode, result queue.
//
//   channel   dir   beat payload                                      handshake
//   in_i      in    char_code                                         valid/ready
//   out_o     out   command glyph cell_col cell_row echo_byte         valid/ready
//                   echo_valid last
//
// A byte is registered on its beat and decoded against the cursor from that register,
// when its one or two results are written into a four-entry result queue.
// A new byte is taken every cycle while decode does not wait; the output gives one
// result a cycle while out_o.ready is high; a byte wrapping the last row gives two.
// Decode waits while the queue has fewer than two free entries.
// Reset puts the cursor at column 0, row 0 and empties the queue.
module text_console_cursor_control (
  input  logic clk_i,
  input  logic rst_ni,
  tcc_char_if.sink  in_i,
  tcc_cmd_if.source out_o
);
  import tcc_pkg::*;

  logic             in_vld_q;
  logic [CharW-1:0] in_char_q;
  logic             space2;
  logic             adv;
  step_t            step;
  result_t          res;

  assign adv      = in_vld_q && space2;
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_code;
    end
  end

  tcc_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .char_i (in_char_q),
    .step_o (step)
  );

  tcc_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (adv),
    .step_i   (step),
    .space2_o (space2),
    .valid_o  (out_o.valid),
    .pop_i    (out_o.ready),
    .res_o    (res)
  );

  assign out_o.command    = res.command;
  assign out_o.glyph      = res.glyph;
  assign out_o.cell_col   = res.cell_col;
  assign out_o.cell_row   = res.cell_row;
  assign out_o.echo_byte  = res.echo_byte;
  assign out_o.echo_valid = res.echo_valid;
  assign out_o.last       = res.last;

endmodule

@@ bench/text_console_cursor_control_test.sv @@
// Testbench of the text console cursor control: byte streams in, renderer commands checked.
`timescale 1ns / 100ps

module text_console_cursor_control_test;
  import tcc_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 16;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tcc_char_if char_bus ();
  tcc_cmd_if  cmd_bus ();

  text_console_cursor_control dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_bus),
    .out_o  (cmd_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cursor as the block should hold it, and the commands still owed by the block.
  int      screen_col;
  int      screen_row;
  result_t pending_commands[$];

  bit send_calm;
  bit recv_calm;

  int error_count;
  int bytes_sent;
  int commands_checked;
  int scrolls_checked;
  int wrap_scrolls_checked;
  int clears_checked;
  int unsigned stall_cycles;

  logic [CharW-1:0] control_codes [6] = '{CH_TAB, CH_LF, CH_FF, CH_CR, CH_ESC, CH_RUBOUT};

  function automatic void predict_commands(input logic [CharW-1:0] c);
    result_t cmd;
    result_t scroll_cmd;
    bit      new_line;
    bit      scrolled;
    cmd            = '0;
    cmd.command    = CMD_NONE;
    cmd.echo_byte  = c;
    cmd.echo_valid = 1'b1;
    cmd.last       = 1'b1;
    new_line       = 1'b0;
    scrolled       = 1'b0;
    case (c)
      CH_RUBOUT: begin
        if (screen_col == 0) begin
          if (screen_row != 0) begin
            screen_row--;
            screen_col = TextCols - 1;
          end
        end else begin
          screen_col--;
        end
        cmd.command  = CMD_DRAW;
        cmd.glyph    = CH_SPACE;
        cmd.cell_col = ColW'(screen_col);
        cmd.cell_row = RowW'(screen_row);
      end
      CH_TAB: begin
        screen_col = screen_col + TabStop - screen_col % TabStop;
        new_line   = screen_col > TextCols - 1;
      end
      CH_FF: begin
        screen_col  = 0;
        screen_row  = 0;
        cmd.command = CMD_CLEAR;
      end
      CH_CR: screen_col = 0;
      CH_LF: new_line = 1'b1;
      CH_ESC: ;
      default: begin
        cmd.command  = CMD_DRAW;
        cmd.glyph    = c;
        cmd.cell_col = ColW'(screen_col);
        cmd.cell_row = RowW'(screen_row);
        screen_col++;
        new_line = screen_col > TextCols - 1;
      end
    endcase
    if (new_line) begin
      screen_col = 0;
      screen_row++;
      if (screen_row >= TextRows) begin
        screen_row = TextRows - 1;
        scrolled   = 1'b1;
      end
    end
    if (scrolled && cmd.command == CMD_DRAW) begin
      // A glyph in the last column of the last row is followed by its own scroll.
      cmd.last = 1'b0;
      pending_commands.push_back(cmd);
      scroll_cmd         = '0;
      scroll_cmd.command = CMD_SCROLL;
      scroll_cmd.last    = 1'b1;
      pending_commands.push_back(scroll_cmd);
    end else begin
      if (scrolled) cmd.command = CMD_SCROLL;
      pending_commands.push_back(cmd);
    end
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input int unsigned got_v,
                               input int unsigned want_v);
    if (got_v != want_v) begin
      report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got_v, want_v));
    end
  endtask

  task automatic check_command();
    result_t want;
    if (pending_commands.size() == 0) begin
      report_error($sformatf("command %s arrived with nothing outstanding",
                             cmd_bus.command.name()));
    end else begin
      want = pending_commands.pop_front();
      compare_field("command", cmd_bus.command, want.command);
      compare_field("glyph", cmd_bus.glyph, want.glyph);
      compare_field("cell_col", cmd_bus.cell_col, want.cell_col);
      compare_field("cell_row", cmd_bus.cell_row, want.cell_row);
      compare_field("echo_byte", cmd_bus.echo_byte, want.echo_byte);
      compare_field("echo_valid", cmd_bus.echo_valid, want.echo_valid);
      compare_field("last", cmd_bus.last, want.last);
      commands_checked++;
      if (want.command == CMD_SCROLL) scrolls_checked++;
      if (want.command == CMD_SCROLL && !want.echo_valid) wrap_scrolls_checked++;
      if (want.command == CMD_CLEAR) clears_checked++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) check_command();
  end

  // No beat on either side for too long means the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (char_bus.valid && char_bus.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("Timeout: no beat for %0d cycles, %0d commands outstanding",
                 StallLimit, pending_commands.size());
        $display("text_console_cursor_control_test: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // The renderer side draws a random stall before each command it takes, none while calm.
  initial begin
    int stall;
    cmd_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        cmd_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cmd_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!cmd_bus.valid) @(posedge clk_i);
    end
  end

  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    @(posedge clk_i);
    while (!char_bus.ready) @(posedge clk_i);
    predict_commands(c);
    bytes_sent++;
  endtask

  task automatic pick_idling();
    send_calm = $urandom_range(0, 3) == 0;
    recv_calm = $urandom_range(0, 3) == 0;
  endtask

  function automatic logic [CharW-1:0] random_glyph();
    logic [CharW-1:0] c;
    do begin
      c = CharW'($urandom_range(0, 255));
    end while (c inside {CH_TAB, CH_LF, CH_FF, CH_CR, CH_ESC, CH_RUBOUT});
    return c;
  endfunction

  task automatic test_glyph_extremes();
    pick_idling();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7E);
    send_char(CH_SPACE);
    send_char(8'h01);
    send_char(8'h1F);
  endtask

  task automatic test_control_codes();
    pick_idling();
    send_char(CH_CR);
    send_char(CH_TAB);
    send_char(CH_TAB);
    send_char(CH_LF);
    send_char(CH_ESC);
    send_char(CH_RUBOUT);
    send_char(CH_FF);
  endtask

  task automatic test_rubout_home();
    pick_idling();
    // At the home cell the cursor stays; from column 0 it wraps to the row above.
    send_char(CH_RUBOUT);
    send_char(CH_LF);
    send_char(CH_RUBOUT);
    send_char(CH_TAB);
    send_char(8'h41);
  endtask

  task automatic test_random_text(input int count);
    int stop_at;
    int len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick_idling();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(75, 170) : $urandom_range(0, 40);
          repeat (len) send_char(random_glyph());
          case ($urandom_range(0, 2))
            0: begin
              send_char(CH_CR);
              send_char(CH_LF);
            end
            1: send_char(CH_LF);
            default: ;
          endcase
        end
        4: repeat ($urandom_range(1, 40)) send_char(CH_LF);
        5: begin
          repeat ($urandom_range(1, 12)) begin
            send_char(CH_TAB);
            if ($urandom_range(0, 2) == 0) send_char(random_glyph());
          end
        end
        6: repeat ($urandom_range(1, 90)) send_char(CH_RUBOUT);
        7: send_char(($urandom_range(0, 3) == 0) ? CH_FF : CH_ESC);
        default: repeat ($urandom_range(1, 8)) send_char(CharW'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_random_bytes(input int count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) pick_idling();
      if ($urandom_range(0, 3) == 0) begin
        send_char(control_codes[3'($urandom_range(0, 5))]);
      end else begin
        send_char(CharW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    screen_col         = 0;
    screen_row         = 0;
    send_calm          = 1'b0;
    recv_calm          = 1'b0;
    error_count        = 0;
    bytes_sent         = 0;
    stall_cycles       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_glyph_extremes();
    test_control_codes();
    test_rubout_home();
    test_random_text(750);
    test_random_bytes(250);

    char_bus.valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes of glyphs, control codes and rubouts; checked %0d commands.",
             bytes_sent, commands_checked);
    $display("Saw %0d scrolls (%0d after a last-column glyph) and %0d screen clears.",
             scrolls_checked, wrap_scrolls_checked, clears_checked);
    if (error_count == 0) begin
      $display("text_console_cursor_control_test: clean");
    end else begin
      $display("text_console_cursor_control_test: errors");
    end
    $finish;
  end

endmodule

@@ text_console_cursor_control.f @@
rtl/core/tcc_pkg.sv
rtl/core/tcc_stream_if.sv
rtl/core/tcc_cursor.sv
rtl/core/tcc_res_fifo.sv
rtl/core/text_console_cursor_control.sv
bench/text_console_cursor_control_test.sv
